[hdl/mono_framebuffer_plotter_core_macros.svh]
// Assertion macros for the frame-store plotter RTL; mfp_rmw is the file that includes them.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef MONO_FRAMEBUFFER_PLOTTER_CORE_MACROS_SVH
`define MONO_FRAMEBUFFER_PLOTTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mfp_pkg.sv]
// Package for the frame-store plotter: action codes, pipeline types and constants.
// It has no dependencies and is used by every module of the block but mfp_frame_ram.
`default_nettype none

package mfp_pkg;

  // Widths fixed by the item format.
  localparam int COORD_W      = 8;
  localparam int STORE_ADDR_W = 13;
  localparam int TDATA_W      = 56;

  // Bit positions of the fields in s_tdata.
  localparam int X_LSB      = 0;
  localparam int Y_LSB      = 8;
  localparam int W_LSB      = 16;
  localparam int H_LSB      = 24;
  localparam int COLOUR_BIT = 32;
  localparam int BADDR_LSB  = 33;
  localparam int BVAL_LSB   = 46;

  localparam logic [7:0] MASK_MSB   = 8'h80;
  localparam logic [7:0] BYTE_WHITE = 8'hFF;

  typedef enum logic [1:0] {
    ACT_PLOT  = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } mem_op_t;

  // One memory access on its way through the read-modify-write path.
  typedef struct packed {
    logic                    valid;
    mem_op_t                 op;
    logic                    hit;
    logic [STORE_ADDR_W-1:0] addr;
    logic [7:0]              mask;
    logic                    set;
    logic [7:0]              value;
  } pipe_op_t;

  // Status returned from the read-modify-write stage to the front end.
  typedef struct packed {
    logic clr_busy;
    logic rd_busy;
  } rmw_status_t;

endpackage

`default_nettype wire

[hdl/mfp_frame_ram.sv]
// Frame-store memory: one write port and one registered read port.
// Depends on nothing but its parameters.
`default_nettype none

module mfp_frame_ram #(
  parameter int DEPTH  = 5000,
  parameter int ADDR_W = 13
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  // Read returns the contents before any write in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/mfp_pixel_gen.sv]
// Front end: accepts items, walks rectangles pixel by pixel, rotates and
// bounds-checks each pixel and issues one memory access per cycle. Uses mfp_pkg.
`default_nettype none

module mfp_pixel_gen #(
  parameter int PANEL_WIDTH  = 200,
  parameter int PANEL_HEIGHT = 200
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_wdata,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [mfp_pkg::TDATA_W-1:0]  s_tdata,
  input  wire logic [1:0]                   s_tuser,
  input  wire mfp_pkg::rmw_status_t         status,
  output mfp_pkg::pipe_op_t                 s1
);

  import mfp_pkg::*;

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;

  localparam logic [8:0]        W9     = 9'(PANEL_WIDTH);
  localparam logic [8:0]        H9     = 9'(PANEL_HEIGHT);
  localparam logic signed [9:0] W_S    = 10'(PANEL_WIDTH);
  localparam logic signed [9:0] H_S    = 10'(PANEL_HEIGHT);
  localparam logic [5:0]        ROW_B  = 6'(ROW_BYTES);
  localparam logic [13:0]       STORE_B = 14'(STORE_BYTES);

  // Item fields.
  action_t                 in_act;
  logic [7:0]              in_x, in_y, in_w, in_h, in_val;
  logic                    in_colour;
  logic [STORE_ADDR_W-1:0] in_baddr;

  assign in_act    = action_t'(s_tuser);
  assign in_x      = s_tdata[X_LSB +: 8];
  assign in_y      = s_tdata[Y_LSB +: 8];
  assign in_w      = s_tdata[W_LSB +: 8];
  assign in_h      = s_tdata[H_LSB +: 8];
  assign in_colour = s_tdata[COLOUR_BIT];
  assign in_baddr  = s_tdata[BADDR_LSB +: STORE_ADDR_W];
  assign in_val    = s_tdata[BVAL_LSB +: 8];

  // Walker registers.
  logic                    busy;
  action_t                 act;
  logic [1:0]              rotation;
  logic [8:0]              cur_x, cur_y, x_start, x_end, y_end;
  logic                    colour;
  logic [STORE_ADDR_W-1:0] baddr;
  logic [7:0]              bval;

  // A read waits until no earlier read result is pending anywhere.
  logic s1_rd, accept;
  assign s1_rd    = s1.valid && (s1.op == OP_READ);
  assign s_tready = !busy && !status.clr_busy &&
                    ((in_act != ACT_READ) || (!status.rd_busy && !s1_rd));
  assign accept   = s_tvalid && s_tready;

  // Rectangle end points, clipped to the panel.
  logic [8:0] sum_x, sum_y, clip_x, clip_y;
  logic       fill_empty;
  assign sum_x      = 9'(in_x) + 9'(in_w);
  assign sum_y      = 9'(in_y) + 9'(in_h);
  assign clip_x     = (sum_x > W9) ? W9 : sum_x;
  assign clip_y     = (sum_y > H9) ? H9 : sum_y;
  assign fill_empty = (clip_x <= 9'(in_x)) || (clip_y <= 9'(in_y));

  // Rotation of the current pixel.
  logic signed [9:0] sx, sy, rx, ry;
  logic              in_panel, rot_ok;
  assign sx = signed'({2'b00, cur_x[7:0]});
  assign sy = signed'({2'b00, cur_y[7:0]});

  always_comb begin
    case (rotation)
      2'd1: begin
        rx = W_S - 10'sd1 - sy;
        ry = sx;
      end
      2'd2: begin
        rx = W_S - 10'sd1 - sx;
        ry = H_S - 10'sd1 - sy;
      end
      2'd3: begin
        rx = sy;
        ry = H_S - 10'sd1 - sx;
      end
      default: begin
        rx = sx;
        ry = sy;
      end
    endcase
  end

  assign in_panel = (cur_x < W9) && (cur_y < H9);
  assign rot_ok   = (rx >= 10'sd0) && (rx < W_S) && (ry >= 10'sd0) && (ry < H_S);

  // Byte address and bit mask of the rotated pixel.
  logic [13:0]             prod;
  logic [STORE_ADDR_W-1:0] pix_addr;
  assign prod     = 14'(ry[7:0]) * 14'(ROW_B);
  assign pix_addr = STORE_ADDR_W'(prod + 14'(rx[7:3]));

  // Access issued this cycle.
  pipe_op_t s1_next;
  always_comb begin
    s1_next       = '0;
    s1_next.op    = OP_PIXEL;
    s1_next.valid = busy;
    s1_next.set   = colour;
    s1_next.value = bval;
    case (act)
      ACT_WRITE: begin
        s1_next.op   = OP_WRITE;
        s1_next.hit  = {1'b0, baddr} < STORE_B;
        s1_next.addr = baddr;
      end
      ACT_READ: begin
        s1_next.op   = OP_READ;
        s1_next.hit  = {1'b0, baddr} < STORE_B;
        s1_next.addr = baddr;
      end
      default: begin
        s1_next.op   = OP_PIXEL;
        s1_next.hit  = in_panel && rot_ok;
        s1_next.addr = pix_addr;
        s1_next.mask = MASK_MSB >> rx[2:0];
      end
    endcase
  end

  logic x_last, y_last, single;
  assign x_last = (cur_x + 9'd1) == x_end;
  assign y_last = (cur_y + 9'd1) == y_end;
  assign single = (act == ACT_WRITE) || (act == ACT_READ);

  // Item capture, rectangle walk and the rotation register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rotation <= 2'd0;
      s1       <= '0;
    end else begin
      s1 <= s1_next;
      if (cfg_we) begin
        rotation <= cfg_wdata;
      end
      if (accept) begin
        act     <= in_act;
        cur_x   <= 9'(in_x);
        cur_y   <= 9'(in_y);
        x_start <= 9'(in_x);
        colour  <= in_colour;
        baddr   <= in_baddr;
        bval    <= in_val;
        if (in_act == ACT_FILL) begin
          x_end <= clip_x;
          y_end <= clip_y;
          busy  <= !fill_empty;
        end else begin
          x_end <= 9'(in_x) + 9'd1;
          y_end <= 9'(in_y) + 9'd1;
          busy  <= 1'b1;
        end
      end else if (busy) begin
        if (single || (x_last && y_last)) begin
          busy <= 1'b0;
        end else if (x_last) begin
          cur_x <= x_start;
          cur_y <= cur_y + 9'd1;
        end else begin
          cur_x <= cur_x + 9'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hdl/mfp_rmw.sv]
// Read-modify-write stage: merges memory data with the last write, writes the
// new byte back, runs the clearing pass and holds the read result. Uses mfp_pkg.
`default_nettype none
`include "mono_framebuffer_plotter_core_macros.svh"

module mfp_rmw #(
  parameter int DEPTH  = 5000,
  parameter int ADDR_W = 13
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mfp_pkg::pipe_op_t s1,
  input  wire logic [7:0]        rdata,
  output logic [ADDR_W-1:0]      raddr,
  output logic                   we,
  output logic [ADDR_W-1:0]      waddr,
  output logic [7:0]             wdata,
  output mfp_pkg::rmw_status_t   status,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata
);

  import mfp_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  pipe_op_t                s2;
  logic                    s2_rd;
  logic                    fwd_valid;
  logic [STORE_ADDR_W-1:0] fwd_addr;
  logic [7:0]              fwd_data;
  logic                    clr_busy;
  logic [ADDR_W-1:0]       clr_addr;
  logic                    out_valid;
  logic [7:0]              out_data;

  assign raddr = s1.addr[ADDR_W-1:0];
  assign s2_rd = s2.valid && (s2.op == OP_READ);

  // The write of the previous cycle is not yet in the read data.
  logic [7:0] merged, new_byte;
  logic       pipe_we;
  assign merged = (fwd_valid && (fwd_addr == s2.addr)) ? fwd_data : rdata;

  always_comb begin
    case (s2.op)
      OP_PIXEL: new_byte = s2.set ? (merged | s2.mask) : (merged & ~s2.mask);
      OP_WRITE: new_byte = s2.value;
      default:  new_byte = merged;
    endcase
  end

  assign pipe_we = s2.valid && s2.hit && (s2.op != OP_READ);

  // The clearing pass owns the write port until it ends.
  assign we    = clr_busy || pipe_we;
  assign waddr = clr_busy ? clr_addr : s2.addr[ADDR_W-1:0];
  assign wdata = clr_busy ? BYTE_WHITE : new_byte;

  assign status.clr_busy = clr_busy;
  assign status.rd_busy  = out_valid || s2_rd;
  assign m_tvalid        = out_valid;
  assign m_tdata         = out_data;

  // Pipeline, forwarding, clearing pass and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2        <= '0;
      fwd_valid <= 1'b0;
      clr_busy  <= 1'b1;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      s2        <= s1;
      fwd_valid <= pipe_we;
      fwd_addr  <= s2.addr;
      fwd_data  <= new_byte;
      if (clr_busy) begin
        if (clr_addr == LAST_ADDR) begin
          clr_busy <= 1'b0;
        end else begin
          clr_addr <= clr_addr + ADDR_W'(1);
        end
      end
      if (s2_rd) begin
        out_valid <= 1'b1;
        out_data  <= s2.hit ? merged : 8'h00;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `MFP_ASSERT_IMP(a_no_access_in_clear, clr_busy, !s2.valid, "access during clearing pass")
  `MFP_ASSERT_IMP(a_read_slot_free, s2_rd, !out_valid, "read result overwrites pending result")
  `MFP_ASSERT_NXT(a_read_reaches_out, s2_rd, out_valid, "read result not presented")

endmodule

`default_nettype wire

[hdl/mono_framebuffer_plotter_core.sv]
// Top level of the one-bit frame-store plotter. Instantiates mfp_pixel_gen,
// mfp_rmw and mfp_frame_ram, and uses mfp_pkg.
`default_nettype none

// After reset the block runs a clearing pass that writes 0xFF to every byte of
// the store, ROW_BYTES * PANEL_HEIGHT bytes (5000 with the default panel); no
// item is accepted until it ends, though rotation writes are taken. No new item
// is taken while the accesses of the last one are being issued, and each
// access is a read-modify-write through the single memory, one per cycle: a
// pixel plot or byte write makes one access, a rectangle fill one per pixel
// after clipping to the panel, and a byte read goes through the s1 and s2
// registers into the output register. A further read is accepted only once the previous read
// result has been transferred; other actions continue while it waits.
module mono_framebuffer_plotter_core #(
  parameter int PANEL_WIDTH  = 200,
  parameter int PANEL_HEIGHT = 200
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_wdata,  // rotation_mode
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // coord_x[7:0], coord_y[15:8], rect_width[23:16], rect_height[31:24],
  // pixel_colour[32], byte_address[45:33], byte_value[53:46], zeros[55:54]
  input  wire logic [mfp_pkg::TDATA_W-1:0] s_tdata,
  input  wire logic [1:0]                  s_tuser,    // action
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [7:0]                       m_tdata     // read_value
);

  import mfp_pkg::*;

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  pipe_op_t          s1;
  rmw_status_t       status;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata;

  // Item front end and rectangle walker.
  mfp_pixel_gen #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_gen (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .status   (status),
    .s1       (s1)
  );

  // Read-modify-write path and result register.
  mfp_rmw #(
    .DEPTH (STORE_BYTES),
    .ADDR_W(ADDR_W)
  ) u_rmw (
    .clk     (clk),
    .rst     (rst),
    .s1      (s1),
    .rdata   (rdata),
    .raddr   (raddr),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .status  (status),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // Frame store.
  mfp_frame_ram #(
    .DEPTH (STORE_BYTES),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for mono_framebuffer_plotter_core: it keeps its own copy
// of the one-bit frame store and checks every byte-read result against it.
// Depends on mfp_pkg and the plotter RTL only.
`timescale 1ns / 1ps

module tb;
  import mfp_pkg::*;

  localparam int PANEL_W     = 200;
  localparam int PANEL_H     = 200;
  localparam int ROW_BYTES   = (PANEL_W + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_H;

  // Rotation register settings.
  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_90   = 2'd1;
  localparam logic [1:0] ROT_180  = 2'd2;
  localparam logic [1:0] ROT_270  = 2'd3;

  typedef struct {
    action_t                 act;
    logic [7:0]              x;
    logic [7:0]              y;
    logic [7:0]              w;
    logic [7:0]              h;
    logic                    colour;
    logic [STORE_ADDR_W-1:0] baddr;
    logic [7:0]              bval;
  } plot_item_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_wdata;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;
  logic [1:0]         s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [7:0]         m_tdata;

  // Shadow frame store, rotation setting and the byte reads still owed by the block.
  logic [7:0] panel_bytes [0:STORE_BYTES-1];
  logic [1:0] rot_mode;
  logic [7:0] pending_reads [$];
  logic [7:0] want_byte;
  int         error_count;
  int         last_item_cycles;
  int         recent_addr;
  int         big_fills_left;
  int         stall_left;
  bit         src_idle_on;
  bit         sink_idle_on;
  bit         long_hold_req;

  mono_framebuffer_plotter_core #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Maps a panel pixel through the rotation onto a store byte and bit mask.
  function automatic bit locate_pixel(input int x, input int y, output int addr,
                                      output logic [7:0] mask);
    int px, py;
    if (x < 0 || y < 0 || x >= PANEL_W || y >= PANEL_H) return 0;
    case (rot_mode)
      ROT_90: begin
        px = PANEL_W - 1 - y;
        py = x;
      end
      ROT_180: begin
        px = PANEL_W - 1 - x;
        py = PANEL_H - 1 - y;
      end
      ROT_270: begin
        px = y;
        py = PANEL_H - 1 - x;
      end
      default: begin
        px = x;
        py = y;
      end
    endcase
    if (px < 0 || py < 0 || px >= PANEL_W || py >= PANEL_H) return 0;
    addr = px / 8 + py * ROW_BYTES;
    if (addr >= STORE_BYTES) return 0;
    mask = MASK_MSB >> (px % 8);
    return 1;
  endfunction

  function automatic void plot_pixel(input int x, input int y, input logic colour);
    int         addr;
    logic [7:0] mask;
    if (locate_pixel(x, y, addr, mask)) begin
      if (colour) begin
        panel_bytes[addr] = panel_bytes[addr] | mask;
      end else begin
        panel_bytes[addr] = panel_bytes[addr] & ~mask;
      end
      recent_addr = addr;
    end
  endfunction

  // Updates the shadow store for one accepted item and queues the byte a read returns.
  function automatic void apply_action(input action_t act, input logic [TDATA_W-1:0] d);
    int   x, y, w, h, addr, x_end, y_end, i, j;
    logic colour;
    x      = int'(d[X_LSB +: COORD_W]);
    y      = int'(d[Y_LSB +: COORD_W]);
    w      = int'(d[W_LSB +: COORD_W]);
    h      = int'(d[H_LSB +: COORD_W]);
    colour = d[COLOUR_BIT];
    addr   = int'(d[BADDR_LSB +: STORE_ADDR_W]);
    case (act)
      ACT_PLOT: begin
        plot_pixel(x, y, colour);
        last_item_cycles = 2;
      end
      ACT_FILL: begin
        x_end = (x + w > PANEL_W) ? PANEL_W : x + w;
        y_end = (y + h > PANEL_H) ? PANEL_H : y + h;
        last_item_cycles = 1;
        for (j = y; j < y_end; j++) begin
          for (i = x; i < x_end; i++) begin
            plot_pixel(i, j, colour);
            last_item_cycles++;
          end
        end
      end
      ACT_WRITE: begin
        if (addr < STORE_BYTES) begin
          panel_bytes[addr] = d[BVAL_LSB +: 8];
          recent_addr = addr;
        end
        last_item_cycles = 2;
      end
      default: begin
        pending_reads.push_back((addr < STORE_BYTES) ? panel_bytes[addr] : 8'h00);
        last_item_cycles = 3;
      end
    endcase
  endfunction

  // Checks each result transfer, then follows register writes and accepted items.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_reads.size() == 0) begin
          $display("%0t: read_value with none outstanding: expected nothing, got %02h",
                   $time, m_tdata);
          error_count++;
        end else begin
          want_byte = pending_reads.pop_front();
          if (m_tdata !== want_byte) begin
            $display("%0t: read_value mismatch: expected %02h, got %02h",
                     $time, want_byte, m_tdata);
            error_count++;
          end
        end
      end
      if (cfg_we) rot_mode = cfg_wdata;
      if (s_tvalid && s_tready) apply_action(action_t'(s_tuser), s_tdata);
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    m_tready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = 300;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offers one item, after an optional idle burst, and returns on its transfer.
  task automatic send_item(input plot_item_t it);
    logic [TDATA_W-1:0] d;
    d = '0;
    d[X_LSB +: COORD_W]         = it.x;
    d[Y_LSB +: COORD_W]         = it.y;
    d[W_LSB +: COORD_W]         = it.w;
    d[H_LSB +: COORD_W]         = it.h;
    d[COLOUR_BIT]               = it.colour;
    d[BADDR_LSB +: STORE_ADDR_W] = it.baddr;
    d[BVAL_LSB +: 8]            = it.bval;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= it.act;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic plot_item_t make_item(input action_t act, input int x, input int y,
                                           input int w, input int h, input bit colour,
                                           input int baddr, input int bval);
    plot_item_t it;
    it.act    = act;
    it.x      = 8'(x);
    it.y      = 8'(y);
    it.w      = 8'(w);
    it.h      = 8'(h);
    it.colour = colour;
    it.baddr  = STORE_ADDR_W'(baddr);
    it.bval   = 8'(bval);
    return it;
  endfunction

  // Random item: fields that the action ignores still carry random bits.
  function automatic plot_item_t random_item();
    plot_item_t it;
    int         pick, where;
    pick      = $urandom_range(0, 99);
    where     = $urandom_range(0, 19);
    it.x      = 8'($urandom);
    it.y      = 8'($urandom);
    it.w      = 8'($urandom);
    it.h      = 8'($urandom);
    it.colour = 1'($urandom_range(0, 1));
    it.baddr  = STORE_ADDR_W'($urandom_range(0, 8191));
    it.bval   = 8'($urandom);
    if (pick < 35) begin
      it.act = ACT_PLOT;
      if (where != 0) begin
        it.x = 8'($urandom_range(0, PANEL_W - 1));
        it.y = 8'($urandom_range(0, PANEL_H - 1));
      end
    end else if (pick < 50) begin
      it.act = ACT_FILL;
      it.x   = 8'($urandom_range(0, PANEL_W + 5));
      it.y   = 8'($urandom_range(0, PANEL_H + 5));
      // Large rectangles are slow, so only a handful keep their full size.
      if (big_fills_left > 0 && $urandom_range(0, 39) == 0) begin
        big_fills_left--;
      end else begin
        it.w = 8'($urandom_range(0, 15));
        it.h = 8'($urandom_range(0, 15));
      end
    end else begin
      it.act = (pick < 70) ? ACT_WRITE : ACT_READ;
      if (where < 9) begin
        it.baddr = STORE_ADDR_W'(recent_addr);
      end else if (where < 17) begin
        it.baddr = STORE_ADDR_W'($urandom_range(0, STORE_BYTES - 1));
      end else begin
        it.baddr = STORE_ADDR_W'($urandom_range(STORE_BYTES, 8191));
      end
    end
    return it;
  endfunction

  // Waits until every read has returned and the last item's accesses have finished.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (last_item_cycles + 20) @(posedge clk);
  endtask

  task automatic set_rotation(input logic [1:0] mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // The cleared store reads white at its first and last byte; reads past the store answer zero.
  task automatic test_reset_contents();
    send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, STORE_BYTES - 1, 0));
    send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, STORE_BYTES, 0));
    send_item(make_item(ACT_READ, 255, 255, 255, 255, 1, 8191, 255));
  endtask

  // Corner pixels, pixels just off the panel, and setting a cleared bit again.
  task automatic test_plot_edges();
    send_item(make_item(ACT_PLOT, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_PLOT, PANEL_W - 1, PANEL_H - 1, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_PLOT, PANEL_W, 7, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_PLOT, 7, PANEL_H, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_PLOT, 255, 255, 255, 255, 0, 8191, 255));
    send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, STORE_BYTES - 1, 0));
    send_item(make_item(ACT_PLOT, 0, 0, 0, 0, 1, 0, 0));
    send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Raw byte writes inside and beyond the store, and reads of the bytes written inside it.
  task automatic test_byte_access();
    send_item(make_item(ACT_WRITE, 0, 0, 0, 0, 0, 0, 8'h5A));
    send_item(make_item(ACT_WRITE, 0, 0, 0, 0, 0, STORE_BYTES - 1, 8'h00));
    send_item(make_item(ACT_WRITE, 0, 0, 0, 0, 0, 8191, 8'h00));
    send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, STORE_BYTES - 1, 0));
  endtask

  // Empty rectangles, one running past the edge, one wholly off, then the whole panel.
  task automatic test_fill_edges();
    send_item(make_item(ACT_FILL, 10, 10, 0, 9, 0, 0, 0));
    send_item(make_item(ACT_FILL, 10, 10, 9, 0, 0, 0, 0));
    send_item(make_item(ACT_FILL, PANEL_W - 5, PANEL_H - 5, 255, 255, 0, 0, 0));
    send_item(make_item(ACT_FILL, PANEL_W, PANEL_H, 255, 255, 0, 0, 0));
    send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, (PANEL_H - 5) * ROW_BYTES + 24, 0));
    send_item(make_item(ACT_FILL, 0, 0, 255, 255, 0, 0, 0));
    send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, STORE_BYTES / 2, 0));
  endtask

  // White pixels on the black panel under each rotation, read back where they land.
  task automatic test_rotation();
    int         xs [5];
    int         ys [5];
    int         addr;
    logic [7:0] mask;
    logic [1:0] modes [4];
    xs    = '{0, PANEL_W - 1, 0, PANEL_W - 1, 37};
    ys    = '{0, 0, PANEL_H - 1, PANEL_H - 1, 150};
    modes = '{ROT_90, ROT_180, ROT_270, ROT_NONE};
    foreach (modes[m]) begin
      wait_idle();
      set_rotation(modes[m]);
      foreach (xs[k]) send_item(make_item(ACT_PLOT, xs[k], ys[k], 0, 0, 1, 0, 0));
      foreach (xs[k]) begin
        if (locate_pixel(xs[k], ys[k], addr, mask)) begin
          send_item(make_item(ACT_READ, 0, 0, 0, 0, 0, addr, 0));
        end
      end
    end
  endtask

  task automatic test_random_mix(input logic [1:0] mode, input int count);
    wait_idle();
    set_rotation(mode);
    repeat (count) send_item(random_item());
  endtask

  // The receiver holds off while reads keep coming, so the input has to stall.
  task automatic test_backpressure();
    plot_item_t it;
    long_hold_req = 1'b1;
    for (int n = 0; n < 40; n++) begin
      it = random_item();
      if (n % 2 == 0) it.act = ACT_READ;
      send_item(it);
    end
  endtask

  // Back-to-back transfers on both sides.
  task automatic test_steady_stream();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (120) send_item(random_item());
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_wdata  <= ROT_NONE;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= ACT_PLOT;
    foreach (panel_bytes[i]) panel_bytes[i] = BYTE_WHITE;
    rot_mode         = ROT_NONE;
    error_count      = 0;
    last_item_cycles = 0;
    recent_addr      = 0;
    big_fills_left   = 4;
    stall_left       = 0;
    src_idle_on      = 1'b1;
    sink_idle_on     = 1'b1;
    long_hold_req    = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_rotation(ROT_NONE);

    test_reset_contents();
    test_plot_edges();
    test_byte_access();
    test_fill_edges();
    test_rotation();
    test_random_mix(ROT_90, 280);
    test_random_mix(ROT_180, 280);
    test_random_mix(ROT_270, 280);
    test_random_mix(ROT_NONE, 280);
    test_backpressure();
    test_steady_stream();
    wait_idle();

    if (error_count == 0 && pending_reads.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
